// ===== hdl/crs_pkg.sv =====
// Shared types and constants for the clip rectangle stack.
// Holds the stack entry layout, operation codes and sizing constants; no dependencies.

package crs_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_POP   = 2'd1,
        FUNC_CLEAR = 2'd2
    } crs_func_t;

    // One stored scissor rectangle, 62 bits.
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic        [14:0] w;
        logic        [14:0] h;
    } crs_rect_t;

    // Shift controls that every cell of the stack sees.
    typedef struct packed {
        logic push;
        logic pop;
    } crs_shift_t;

endpackage

// ===== hdl/crs_cell.sv =====
// One cell of the shifting clip stack: holds one rectangle.
// Depends on crs_pkg for the entry and shift-control types.

module crs_cell (
    input  logic               aclk,
    input  crs_pkg::crs_shift_t shift,
    input  crs_pkg::crs_rect_t  from_above,
    input  crs_pkg::crs_rect_t  from_below,
    output crs_pkg::crs_rect_t  entry
);
    import crs_pkg::*;

    crs_rect_t entry_reg;
    crs_rect_t entry_next;

    // A push moves every entry one cell deeper; a pop moves them back up.
    always_comb begin
        entry_next = entry_reg;
        if (shift.push) begin
            entry_next = from_above;
        end else if (shift.pop) begin
            entry_next = from_below;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== hdl/crs_isect.sv =====
// Rectangle intersection of the stack top with an incoming rectangle.
// Depends on crs_pkg for the rectangle type.

module crs_isect (
    input  crs_pkg::crs_rect_t a,
    input  crs_pkg::crs_rect_t b,
    output crs_pkg::crs_rect_t r
);
    import crs_pkg::*;

    logic signed [17:0] ax, ay, bx, by;
    logic signed [17:0] ax2, ay2, bx2, by2;
    logic signed [17:0] x1, y1, x2, y2;
    logic signed [17:0] dw, dh;

    always_comb begin
        ax  = 18'(a.x);
        ay  = 18'(a.y);
        bx  = 18'(b.x);
        by  = 18'(b.y);
        ax2 = ax + $signed({3'b000, a.w});
        ay2 = ay + $signed({3'b000, a.h});
        bx2 = bx + $signed({3'b000, b.w});
        by2 = by + $signed({3'b000, b.h});
        x1  = (ax > bx) ? ax : bx;
        y1  = (ay > by) ? ay : by;
        x2  = (ax2 < bx2) ? ax2 : bx2;
        y2  = (ay2 < by2) ? ay2 : by2;
        // An empty overlap collapses to zero size at the max edge.
        dw  = (x2 < x1) ? 18'sd0 : x2 - x1;
        dh  = (y2 < y1) ? 18'sd0 : y2 - y1;
        r.x = x1[15:0];
        r.y = y1[15:0];
        r.w = dw[14:0];
        r.h = dh[14:0];
    end

endmodule

// ===== hdl/clip_rectangle_stack_core.sv =====
// Top level of the nested scissor clip stack.
// Depends on crs_pkg, crs_cell and crs_isect.
//
// Usage:
//   The slave channel carries commands: s_tuser holds the operation (push,
//   pop, clear stack) and s_tdata the rectangle for a push. The master
//   channel carries the active scissor: m_tuser is the enable flag and
//   m_tdata the rectangle, all zero when the scissor is disabled.
//   A push or a pop produces exactly one result beat; a clear or the unused
//   code produces none. The stack is a row of STACK_DEPTH cells with the top
//   entry in the first cell, so each command is resolved from the first two
//   cells and the row shifts by one place in the same cycle.
//   The result of an accepted beat is in the output register in the cycle after
//   it is accepted. Throughput is one command per cycle: s_tready stays high as
//   long as the output register is empty or being drained in that cycle.
//   When the receiver stalls, the result is held and s_tready drops until it
//   is taken; nothing is dropped.
//   Reset (aresetn low, synchronous) empties the stack and the output
//   register; no result is emitted for it.

module clip_rectangle_stack_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // rect_x[15:0], rect_y[31:16], rect_w[47:32], rect_h[63:48]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // clip_x[15:0], clip_y[31:16], clip_w[46:32], clip_h[61:47]
    output logic [0:0]  m_tuser    // scissor_on[0]
);
    import crs_pkg::*;

    logic signed [15:0] rect_x, rect_y, rect_w, rect_h;
    logic               s_accept;
    crs_rect_t          clamped;
    crs_rect_t          isect;
    crs_rect_t          push_rect;
    crs_shift_t         shift;
    crs_rect_t          cell_q [0:STACK_DEPTH];
    crs_rect_t          above  [0:STACK_DEPTH-1];

    logic [CNT_W-1:0]   count_reg, count_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_on_reg, m_on_next;
    crs_rect_t          m_data_reg, m_data_next;
    logic               emit;
    logic               emit_on;
    crs_rect_t          emit_rect;

    assign rect_x = s_tdata[15:0];
    assign rect_y = s_tdata[31:16];
    assign rect_w = s_tdata[47:32];
    assign rect_h = s_tdata[63:48];

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // Negative sizes count as zero.
    always_comb begin
        clamped.x = rect_x;
        clamped.y = rect_y;
        clamped.w = rect_w[15] ? 15'd0 : rect_w[14:0];
        clamped.h = rect_h[15] ? 15'd0 : rect_h[14:0];
    end

    crs_isect u_isect (
        .a (cell_q[0]),
        .b (clamped),
        .r (isect)
    );

    assign push_rect = (count_reg != '0) ? isect : clamped;

    // Stack control and result selection.
    always_comb begin
        shift      = '0;
        count_next = count_reg;
        emit       = 1'b0;
        emit_on    = 1'b0;
        emit_rect  = '0;
        if (s_accept) begin
            case (s_tuser)
                FUNC_PUSH: begin
                    emit      = 1'b1;
                    emit_on   = 1'b1;
                    emit_rect = push_rect;
                    if (count_reg < CNT_W'(STACK_DEPTH)) begin
                        shift.push = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                FUNC_POP: begin
                    emit = 1'b1;
                    if (count_reg != '0) begin
                        shift.pop  = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                    // The second cell becomes the new top after the pop.
                    if (count_reg > CNT_W'(1)) begin
                        emit_on   = 1'b1;
                        emit_rect = cell_q[1];
                    end
                end
                FUNC_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    genvar i;
    generate
        for (i = 0; i < STACK_DEPTH; i++) begin : g_cell
            if (i == 0) begin : g_top
                assign above[i] = push_rect;
            end else begin : g_rest
                assign above[i] = cell_q[i-1];
            end
            crs_cell u_cell (
                .aclk       (aclk),
                .shift      (shift),
                .from_above (above[i]),
                .from_below (cell_q[i+1]),
                .entry      (cell_q[i])
            );
        end
    endgenerate

    // The deepest cell keeps its own value on a pop.
    assign cell_q[STACK_DEPTH] = cell_q[STACK_DEPTH-1];

    always_comb begin
        m_valid_next = m_valid_reg;
        m_on_next    = m_on_reg;
        m_data_next  = m_data_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_on_next    = emit_on;
            m_data_next  = emit_rect;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        m_on_reg   <= m_on_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tuser[0] = m_on_reg;
    assign m_tdata    = {2'b00, m_data_reg.h, m_data_reg.w, m_data_reg.y, m_data_reg.x};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tuser == FUNC_CLEAR |=> count_reg == '0)
        else $error("clear did not empty the stack");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tuser == FUNC_PUSH && count_reg < CNT_W'(STACK_DEPTH)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push on a non-full stack did not add an entry");

    a_off_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_on_reg |-> m_data_reg == '0)
        else $error("disabled scissor carries a nonzero rectangle");

    a_pop_empty_off: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tuser == FUNC_POP && count_reg <= CNT_W'(1)
        |=> m_valid_reg && !m_on_reg)
        else $error("pop to an empty stack did not disable the scissor");

endmodule
